// ===== rtl/char_lcd_write_sequencer_core_macros.svh =====
// Assertion macros shared by the character-LCD write sequencer modules.
`ifndef CHAR_LCD_WRITE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/clws_pkg.sv =====
// Types and constants shared by the character-LCD write sequencer.
package clws_pkg;

  localparam logic [2:0] CMD_PUT_CHAR = 3'd0;
  localparam logic [2:0] CMD_CLEAR    = 3'd1;
  localparam logic [2:0] CMD_HOME     = 3'd2;
  localparam logic [2:0] CMD_SET_ADDR = 3'd3;
  localparam logic [2:0] CMD_INIT     = 3'd4;
  localparam logic [2:0] CMD_RESEND   = 3'd5;
  localparam logic [2:0] CMD_SHIFT    = 3'd6;

  localparam logic [2:0] REG_FAST_WAIT       = 3'd0;
  localparam logic [2:0] REG_SLOW_WAIT       = 3'd1;
  localparam logic [2:0] REG_STARTUP_WAIT    = 3'd2;
  localparam logic [2:0] REG_ENTRY_MODE      = 3'd3;
  localparam logic [2:0] REG_DISPLAY_CONTROL = 3'd4;
  localparam logic [2:0] REG_FUNCTION_SET    = 3'd5;

  localparam logic [15:0] FAST_WAIT_RESET       = 16'd160;
  localparam logic [15:0] SLOW_WAIT_RESET       = 16'd6560;
  localparam logic [19:0] STARTUP_WAIT_RESET    = 20'd120000;
  localparam logic [1:0]  ENTRY_MODE_RESET      = 2'd0;
  localparam logic [2:0]  DISPLAY_CONTROL_RESET = 3'd4;
  localparam logic [2:0]  FUNCTION_SET_RESET    = 3'd7;

  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  localparam logic [7:0] INSTR_CLEAR     = 8'h01;
  localparam logic [7:0] INSTR_HOME      = 8'h02;
  localparam logic [7:0] INSTR_ENTRY     = 8'h04;
  localparam logic [7:0] INSTR_DISPLAY   = 8'h08;
  localparam logic [7:0] INSTR_SHIFT     = 8'h10;
  localparam logic [7:0] INSTR_MOVE_LEFT = 8'h10;
  localparam logic [7:0] INSTR_FUNCTION  = 8'h20;

  typedef enum logic [2:0] {
    JOB_DATA,       // one data write
    JOB_INSTR,      // one instruction with the fast wait
    JOB_SLOW,       // one instruction with the slow wait
    JOB_BACKSPACE,  // move left, data space, move left
    JOB_INIT,       // settings after startup wait, then clear
    JOB_RESEND      // settings only
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] payload;
  } job_t;

  typedef struct packed {
    logic [15:0] fast_wait;
    logic [15:0] slow_wait;
    logic [19:0] startup_wait;
    logic [1:0]  entry_mode;
    logic [2:0]  display_control;
    logic [2:0]  function_set;
  } cfg_t;

endpackage

// ===== rtl/clws_front.sv =====
// Front end: accepts requests, keeps the address shadow and classifies each into a job.
module clws_front import clws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [7:0] character,
  input  logic [6:0] address,
  input  logic       shift_display,
  input  logic       move_right,
  input  logic       queue_full,
  output logic       push,
  output job_t       push_job
);

  logic [6:0] address_shadow;
  logic [6:0] address_shadow_next;
  logic       has_job;
  logic       accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && has_job;

  always_comb begin
    address_shadow_next = address_shadow;
    has_job             = 1'b1;
    push_job.kind       = JOB_INSTR;
    push_job.payload    = INSTR_CLEAR;
    case (command)
      CMD_PUT_CHAR: begin
        if (character == CHAR_CR) begin
          address_shadow_next = {address_shadow[6:4], 4'b0000};
          push_job.payload    = {1'b1, address_shadow_next};
        end else if (character == CHAR_LF) begin
          address_shadow_next = {~address_shadow[6], address_shadow[5:0]};
          push_job.payload    = {1'b1, address_shadow_next};
        end else if (character == CHAR_BACKSPACE) begin
          push_job.kind = JOB_BACKSPACE;
        end else begin
          push_job.kind    = JOB_DATA;
          push_job.payload = character;
        end
      end
      CMD_CLEAR: begin
        address_shadow_next = '0;
        push_job.kind       = JOB_SLOW;
        push_job.payload    = INSTR_CLEAR;
      end
      CMD_HOME: begin
        address_shadow_next = '0;
        push_job.kind       = JOB_SLOW;
        push_job.payload    = INSTR_HOME;
      end
      CMD_SET_ADDR: begin
        address_shadow_next = address;
        push_job.payload    = {1'b1, address};
      end
      CMD_INIT: begin
        address_shadow_next = '0;
        push_job.kind       = JOB_INIT;
      end
      CMD_RESEND: begin
        push_job.kind = JOB_RESEND;
      end
      CMD_SHIFT: begin
        push_job.payload = INSTR_SHIFT | {4'b0000, shift_display, move_right, 2'b00};
      end
      default: begin
        // The unused command code is taken and dropped.
        has_job = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_shadow <= '0;
    end else if (accept) begin
      address_shadow <= address_shadow_next;
    end
  end

endmodule

// ===== rtl/clws_queue.sv =====
// Small job queue between the front end and the write sequencer.
`include "char_lcd_write_sequencer_core_macros.svh"
module clws_queue import clws_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic full,
  output logic empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == DepthCnt);
  assign empty    = (count == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CLWS_ASSERT_NOW(a_no_push_full, clk, rst, push, !full, "job pushed into a full queue")
  `CLWS_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !empty, "job popped from an empty queue")
  `CLWS_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue count did not advance")

endmodule

// ===== rtl/clws_back.sv =====
// Back end: expands each job into bus writes and holds the output register.
`include "char_lcd_write_sequencer_core_macros.svh"
module clws_back import clws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        queue_empty,
  input  job_t        head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        register_select,
  output logic [7:0]  bus_byte,
  output logic [19:0] wait_before,
  output logic [15:0] wait_after,
  output logic        last
);

  logic       cur_valid;
  job_t       cur_job;
  logic [1:0] step;
  logic       load;

  logic        wr_rs;
  logic [7:0]  wr_byte;
  logic [19:0] wr_before;
  logic [15:0] wr_after;
  logic        wr_last;

  assign load = cur_valid && (!out_valid || !out_stall);
  assign pop  = !queue_empty && (!cur_valid || (load && wr_last));

  always_comb begin
    wr_rs     = 1'b0;
    wr_byte   = cur_job.payload;
    wr_before = '0;
    wr_after  = cfg.fast_wait;
    wr_last   = 1'b1;
    case (cur_job.kind)
      JOB_DATA: begin
        wr_rs = 1'b1;
      end
      JOB_INSTR: begin
        wr_last = 1'b1;
      end
      JOB_SLOW: begin
        wr_after = cfg.slow_wait;
      end
      JOB_BACKSPACE: begin
        wr_last = (step == 2'd2);
        if (step == 2'd1) begin
          wr_rs   = 1'b1;
          wr_byte = CHAR_SPACE;
        end else begin
          wr_byte = INSTR_MOVE_LEFT;
        end
      end
      JOB_INIT, JOB_RESEND: begin
        wr_last = (cur_job.kind == JOB_INIT) ? (step == 2'd3) : (step == 2'd2);
        case (step)
          2'd0: begin
            wr_byte = INSTR_FUNCTION | {3'b000, cfg.function_set, 2'b00};
            if (cur_job.kind == JOB_INIT) begin
              wr_before = cfg.startup_wait;
            end
          end
          2'd1: wr_byte = INSTR_DISPLAY | {5'b00000, cfg.display_control};
          2'd2: wr_byte = INSTR_ENTRY | {6'b000000, cfg.entry_mode};
          default: begin
            wr_byte  = INSTR_CLEAR;
            wr_after = cfg.slow_wait;
          end
        endcase
      end
      default: begin
        wr_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= load;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        step      <= '0;
      end else if (load) begin
        if (wr_last) begin
          cur_valid <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_job <= head_job;
    end
    if (load) begin
      register_select <= wr_rs;
      bus_byte        <= wr_byte;
      wait_before     <= wr_before;
      wait_after      <= wr_after;
      last            <= wr_last;
    end
  end

  `CLWS_ASSERT_NOW(a_step3_init, clk, rst, cur_valid && step == 2'd3, cur_job.kind == JOB_INIT, "fourth write outside an initialize job")
  `CLWS_ASSERT_NOW(a_multi_step, clk, rst, cur_valid && step != 2'd0, cur_job.kind == JOB_BACKSPACE || cur_job.kind == JOB_INIT || cur_job.kind == JOB_RESEND, "single-write job advanced past its write")
  `CLWS_ASSERT_NEXT(a_load_shows, clk, rst, load, out_valid, "loaded write not presented")

endmodule

// ===== rtl/char_lcd_write_sequencer_core.sv =====
// Character-LCD write sequencer: each request item becomes up to four bus write items (register
// select, byte, wait before and after the strobe); carriage return, line feed and backspace become
// cursor control, clear/home/initialize use the slow wait. The front end takes an item
// whenever the job queue (QueueDepth entries) has room; the back end issues one write per cycle
// whenever the output register is free and a job is loaded, and goes from the last write of one
// item straight on to the next queued item. Configuration is read live when each write is formed.
module char_lcd_write_sequencer_core import clws_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [2:0]  register_index,
  input  logic [19:0] write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  character,
  input  logic [6:0]  address,
  input  logic        shift_display,
  input  logic        move_right,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        register_select,
  output logic [7:0]  bus_byte,
  output logic [19:0] wait_before,
  output logic [15:0] wait_after,
  output logic        last
);

  cfg_t cfg;
  logic push;
  job_t push_job;
  logic pop;
  job_t head_job;
  logic queue_full;
  logic queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_wait       <= FAST_WAIT_RESET;
      cfg.slow_wait       <= SLOW_WAIT_RESET;
      cfg.startup_wait    <= STARTUP_WAIT_RESET;
      cfg.entry_mode      <= ENTRY_MODE_RESET;
      cfg.display_control <= DISPLAY_CONTROL_RESET;
      cfg.function_set    <= FUNCTION_SET_RESET;
    end else if (write_enable) begin
      case (register_index)
        REG_FAST_WAIT:       cfg.fast_wait       <= write_data[15:0];
        REG_SLOW_WAIT:       cfg.slow_wait       <= write_data[15:0];
        REG_STARTUP_WAIT:    cfg.startup_wait    <= write_data;
        REG_ENTRY_MODE:      cfg.entry_mode      <= write_data[1:0];
        REG_DISPLAY_CONTROL: cfg.display_control <= write_data[2:0];
        REG_FUNCTION_SET:    cfg.function_set    <= write_data[2:0];
        default: begin
        end
      endcase
    end
  end

  clws_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .character     (character),
    .address       (address),
    .shift_display (shift_display),
    .move_right    (move_right),
    .queue_full    (queue_full),
    .push          (push),
    .push_job      (push_job)
  );

  clws_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  clws_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .queue_empty     (queue_empty),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .register_select (register_select),
    .bus_byte        (bus_byte),
    .wait_before     (wait_before),
    .wait_after      (wait_after),
    .last            (last)
  );

endmodule
